[hw/rtl/dnf_pkg.sv]
// ----------------------------------------------------------------------------
// dnf_pkg
// Shared types and constants of the decimal number formatter: request and
// response payloads, sequencer states and the converter control interface.
// ----------------------------------------------------------------------------
package dnf_pkg;

   // Field widths fixed by the payload format
   localparam int VALUE_W        = 64;
   localparam int ROW_W          = 2;
   localparam int COLUMN_W       = 5;
   localparam int COUNT_W        = 5;
   localparam int BYTE_W         = 8;
   localparam int DIGIT_W        = 4;
   localparam int BIT_CNT_W      = $clog2(VALUE_W);

   // Default number of low decimal digits kept
   localparam int MAX_DIGITS_DEF = 20;

   // Character and command codes
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic              ADDR_FLAG  = 1'b1;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [ROW_W-1:0]    row;
      logic [COLUMN_W-1:0] column;
      logic [COUNT_W-1:0]  int_digits;
      logic [COUNT_W-1:0]  frac_digits;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_data;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_ADDR,
      S_SKIP,
      S_INT,
      S_DOT,
      S_FRAC,
      S_DASH
   } seq_state_type;

   // Sequencer to converter
   typedef struct packed {
      logic load;
      logic shift;
   } bcd_ctrl_type;

   // Converter to sequencer
   typedef struct packed {
      logic               busy;
      logic [DIGIT_W-1:0] top_digit;
   } bcd_status_type;

endpackage

[hw/rtl/dnf_bcd.sv]
// ----------------------------------------------------------------------------
// dnf_bcd
// Bit-serial binary to BCD converter (shift and add 3). One input bit enters
// per cycle; the digit register then shifts out one digit per cycle on shift,
// most significant first. Only the lowest MAX_DIGITS digits are kept.
// ----------------------------------------------------------------------------
module dnf_bcd
   import dnf_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [VALUE_W-1:0] value,
   input  bcd_ctrl_type   ctrl,
   output bcd_status_type status
);

   localparam int BCD_W = MAX_DIGITS * DIGIT_W;

   logic [VALUE_W-1:0]   bin_ff,  bin_in;
   logic [BCD_W-1:0]     bcd_ff,  bcd_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 busy_ff, busy_in;
   logic [BCD_W-1:0]     adj;

   // Correct every digit of 5 or more before the doubling shift
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   // Load, convert one bit per cycle, or shift out one digit
   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      busy_in    = busy_ff;
      if (ctrl.load) begin
         bin_in     = value;
         bcd_in     = '0;
         bit_cnt_in = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         bin_in     = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in     = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
         if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
         end
      end else if (ctrl.shift) begin
         bcd_in = bcd_ff << DIGIT_W;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         bit_cnt_ff <= bit_cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign status.busy      = busy_ff;
   assign status.top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

`ifndef ASSERT_OFF
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> busy_ff)
      else $error("converter did not start on load");
   a_no_shift_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift |-> !busy_ff)
      else $error("digit shift requested during conversion");
   a_conv_ends: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !ctrl.load && bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1) |=> !busy_ff)
      else $error("conversion did not end after the last bit");
`endif

endmodule

[hw/rtl/dnf_seq.sv]
// ----------------------------------------------------------------------------
// dnf_seq
// Output sequencer: takes a request, starts the converter, then sends the
// cursor address and the character bytes through a one-entry output register.
// ----------------------------------------------------------------------------
module dnf_seq
   import dnf_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data,
   output bcd_ctrl_type   ctrl,
   input  bcd_status_type status
);

   localparam int CW  = $clog2(MAX_DIGITS + 1);
   localparam int TW  = COUNT_W + 1;

   seq_state_type       state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                blank_ff, blank_in;
   logic [ROW_W-1:0]    row_ff;
   logic [COLUMN_W-1:0] column_ff;
   logic [COUNT_W-1:0]  nint_ff, nfrac_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                req_fire;
   logic                out_free;
   logic                emit;
   logic [TW-1:0]       total;
   logic                too_many;
   logic [TW-1:0]       skip;
   logic [TW-1:0]       skip_m1;
   logic [TW-1:0]       nint_m1;
   logic [TW-1:0]       nfrac_m1;
   logic                blank_now;
   logic [BYTE_W-1:0]   digit_char;

   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign total      = {1'b0, nint_ff} + {1'b0, nfrac_ff};
   assign too_many   = total > TW'(MAX_DIGITS);
   assign skip       = TW'(MAX_DIGITS) - total;
   assign skip_m1    = skip - TW'(1);
   assign nint_m1    = {1'b0, nint_ff} - TW'(1);
   assign nfrac_m1   = {1'b0, nfrac_ff} - TW'(1);
   assign blank_now  = blank_ff && status.top_digit == '0 && cnt_ff != '0;
   assign digit_char = CHAR_ZERO | {{(BYTE_W-DIGIT_W){1'b0}}, status.top_digit};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CONV;
         end
         S_CONV: begin
            if (!status.busy) state_in = S_ADDR;
         end
         S_ADDR: begin
            if (out_free) begin
               if (too_many)            state_in = S_DASH;
               else if (total == '0)    state_in = S_IDLE;
               else if (skip != '0)     state_in = S_SKIP;
               else if (nint_ff != '0)  state_in = S_INT;
               else                     state_in = S_DOT;
            end
         end
         S_SKIP: begin
            if (cnt_ff == '0) begin
               if (nint_ff != '0) state_in = S_INT;
               else               state_in = S_DOT;
            end
         end
         S_INT: begin
            if (out_free && cnt_ff == '0) begin
               if (nfrac_ff != '0) state_in = S_DOT;
               else                state_in = S_IDLE;
            end
         end
         S_DOT: begin
            if (out_free) state_in = S_FRAC;
         end
         S_FRAC, S_DASH: begin
            if (out_free && cnt_ff == '0) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs, counters and the response register
   always_comb begin
      req_ready       = 1'b0;
      ctrl            = '0;
      cnt_in          = cnt_ff;
      blank_in        = blank_ff;
      emit            = 1'b0;
      rsp_in          = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         S_CONV: begin
            blank_in = 1'b1;
         end
         S_ADDR: begin
            emit            = out_free;
            rsp_in.out_byte = {ADDR_FLAG, row_ff, column_ff};
            rsp_in.is_data  = 1'b0;
            rsp_in.last     = !too_many && total == '0;
            if (too_many)            cnt_in = CW'(MAX_DIGITS - 1);
            else if (skip != '0)     cnt_in = skip_m1[CW-1:0];
            else                     cnt_in = nint_m1[CW-1:0];
         end
         S_SKIP: begin
            ctrl.shift = 1'b1;
            cnt_in     = cnt_ff - CW'(1);
            if (cnt_ff == '0) cnt_in = nint_m1[CW-1:0];
         end
         S_INT: begin
            emit            = out_free;
            ctrl.shift      = out_free;
            rsp_in.out_byte = blank_now ? CHAR_SPACE : digit_char;
            rsp_in.is_data  = 1'b1;
            rsp_in.last     = cnt_ff == '0 && nfrac_ff == '0;
            if (out_free) begin
               blank_in = blank_now;
               cnt_in   = cnt_ff - CW'(1);
            end
         end
         S_DOT: begin
            emit            = out_free;
            rsp_in.out_byte = CHAR_DOT;
            rsp_in.is_data  = 1'b1;
            rsp_in.last     = 1'b0;
            cnt_in          = nfrac_m1[CW-1:0];
         end
         S_FRAC: begin
            emit            = out_free;
            ctrl.shift      = out_free;
            rsp_in.out_byte = digit_char;
            rsp_in.is_data  = 1'b1;
            rsp_in.last     = cnt_ff == '0;
            if (out_free) cnt_in = cnt_ff - CW'(1);
         end
         S_DASH: begin
            emit            = out_free;
            rsp_in.out_byte = CHAR_DASH;
            rsp_in.is_data  = 1'b1;
            rsp_in.last     = cnt_ff == '0;
            if (out_free) cnt_in = cnt_ff - CW'(1);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      if (!emit) rsp_in = rsp_ff;
      if (emit)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         blank_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         blank_ff     <= blank_in;
      end
      rsp_ff <= rsp_in;
      if (req_fire) begin
         row_ff    <= req_data.row;
         column_ff <= req_data.column;
         nint_ff   <= req_data.int_digits;
         nfrac_ff  <= req_data.frac_digits;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_digits_after_conv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SKIP || state_ff == S_INT || state_ff == S_FRAC) |-> !status.busy)
      else $error("digits read before conversion finished");
   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |->
         (state_ff == S_IDLE || state_ff == S_CONV || state_ff == S_ADDR))
      else $error("sequencer still busy after the last byte");
   a_fire_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_CONV && status.busy)
      else $error("request did not start a conversion");
`endif

endmodule

[hw/rtl/decimal_number_formatter.sv]
// ----------------------------------------------------------------------------
// decimal_number_formatter
// Formats an unsigned 64-bit number as display bytes: a cursor address command
// followed by ASCII digits, blanked leading zeros and a point, or by dashes.
//
// Usage:
//   Request channel (req_valid/req_ready/req_data) takes the number, the
//   display row and column and the integer and fraction digit counts.
//   Response channel (rsp_valid/rsp_ready/rsp_data) returns one byte per
//   transfer; is_data is low on the address byte, last marks the final byte.
//   One request is in flight at a time; req_ready is high while idle, even
//   when the final byte of the previous request still waits in the output
//   register.
//   Order: the taken request starts the bit-serial BCD converter; when the
//   conversion ends the address byte is sent, the dropped high digits, if
//   any, are shifted out, and then the character bytes follow one by one.
//   A stalled receiver holds the output register; the sequencer waits.
//   Reset returns the sequencer to idle and clears the output valid.
// ----------------------------------------------------------------------------
module decimal_number_formatter
   import dnf_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   bcd_ctrl_type   bcd_ctrl;
   bcd_status_type bcd_status;

   // Bit-serial converter
   dnf_bcd #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_bcd (
      .clock  (clock),
      .reset  (reset),
      .value  (req_data.value),
      .ctrl   (bcd_ctrl),
      .status (bcd_status)
   );

   // Byte sequencer and output register
   dnf_seq #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .ctrl      (bcd_ctrl),
      .status    (bcd_status)
   );

endmodule

[bench/dnf_scoreboard.sv]
// ----------------------------------------------------------------------------
// dnf_scoreboard
// Watches the request and response channels of the decimal number formatter.
// Each accepted request is turned into the display bytes it must produce: the
// cursor address, then digits, blanks, point or dashes. Each accepted response
// byte is compared field by field with the oldest byte still owed.
// ----------------------------------------------------------------------------
module dnf_scoreboard
   import dnf_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_bytes,
   output int      requests_taken,
   output int      bytes_taken
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type display_bytes[$];
   rsp_type want;
   int      mismatches;
   int      request_total;
   int      byte_total;

   // Build the byte sequence owed for one request
   function automatic void format_number(input req_type r);
      logic [DIGIT_W-1:0] digit [MAX_DIGITS];
      logic [BYTE_W-1:0]  chars [$];
      logic [VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0] d;
      logic [BYTE_W-1:0]  ch;
      rsp_type            item;
      int                 total;
      int                 pos;
      int                 i;
      bit                 blanking;

      rest  = r.value;
      total = int'(r.int_digits) + int'(r.frac_digits);
      chars.push_back({ADDR_FLAG, r.row, r.column});

      if (total > MAX_DIGITS) begin
         repeat (MAX_DIGITS) chars.push_back(CHAR_DASH);
      end else begin
         // split off the low decimal digits, stored most significant first
         for (i = MAX_DIGITS - 1; i >= 0; i--) begin
            digit[i] = DIGIT_W'(rest % 10);
            rest     = rest / 10;
         end
         pos      = MAX_DIGITS - total;
         blanking = 1'b1;
         // integer part: leading zeros become spaces, bar the last one
         for (i = 0; i < int'(r.int_digits); i++) begin
            d = digit[pos];
            pos++;
            if (blanking && d == '0 && i + 1 < int'(r.int_digits)) begin
               ch = CHAR_SPACE;
            end else begin
               blanking = 1'b0;
               ch       = CHAR_ZERO + BYTE_W'(d);
            end
            chars.push_back(ch);
         end
         if (r.frac_digits != '0) chars.push_back(CHAR_DOT);
         for (i = 0; i < int'(r.frac_digits); i++) begin
            chars.push_back(CHAR_ZERO + BYTE_W'(digit[pos]));
            pos++;
         end
      end

      // queue them, address first, last flag on the final byte
      for (i = 0; i < chars.size(); i++) begin
         item.out_byte = chars[i];
         item.is_data  = (i != 0);
         item.last     = (i == chars.size() - 1);
         display_bytes.push_back(item);
      end
   endfunction

   // Compare responses first, then queue the new request's bytes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            byte_total++;
            if (display_bytes.size() == 0) begin
               $error("response byte %h with nothing owed", rsp_data.out_byte);
               mismatches++;
            end else begin
               want = display_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
                  mismatches++;
               end
               if (rsp_data.is_data !== want.is_data) begin
                  $error("is_data: expected %b, got %b", want.is_data, rsp_data.is_data);
                  mismatches++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_data.last);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            request_total++;
            format_number(req_data);
         end
      end
      fail_count     <= mismatches;
      pending_bytes  <= display_bytes.size();
      requests_taken <= request_total;
      bytes_taken    <= byte_total;
   end

endmodule

[bench/decimal_number_formatter_tb.sv]
// ----------------------------------------------------------------------------
// decimal_number_formatter_tb
// Drives the decimal number formatter with a directed set of edge cases
// (blank and zero counts, digit overflow, maximum value, out-of-range column)
// followed by shaped random requests, with random gaps on both channels and
// one long response stall. The scoreboard checks every byte.
// ----------------------------------------------------------------------------
module decimal_number_formatter_tb
   import dnf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 500;
   localparam int CYCLE_LIMIT     = 4000000;
   localparam int DRAIN_CYCLES    = 100;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int fail_count;
   int pending_bytes;
   int requests_taken;
   int bytes_taken;
   int dash_requests;
   int pointless_requests;
   int cycle_count;

   decimal_number_formatter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   dnf_scoreboard u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending_bytes  (pending_bytes),
      .requests_taken (requests_taken),
      .bytes_taken    (bytes_taken)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("decimal_number_formatter test failed");
      $finish;
   end

   // Response side: random stalls, long ready stretches, one long hold-off
   initial begin
      int  kind;
      int  len;
      bit  level;
      bit  held;
      rsp_ready = 1'b0;
      held      = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         kind = $urandom_range(0, 99);
         if (!held && bytes_taken >= 300) begin
            // hold off long enough for the block to fill and stall requests
            held  = 1'b1;
            level = 1'b0;
            len   = 500;
         end else if (kind < 40) begin
            level = 1'b1;
            len   = $urandom_range(1, 30);
         end else if (kind < 85) begin
            level = 1'b0;
            len   = $urandom_range(1, 3);
         end else if (kind < 93) begin
            level = 1'b0;
            len   = $urandom_range(10, 60);
         end else begin
            level = 1'b1;
            len   = $urandom_range(50, 150);
         end
         repeat (len) begin
            @(negedge clock);
            rsp_ready = level;
         end
      end
   end

   function automatic req_type make_req(input logic [VALUE_W-1:0] value,
                                        input int row, input int column,
                                        input int int_digits, input int frac_digits);
      req_type r;
      r.value       = value;
      r.row         = ROW_W'(row);
      r.column      = COLUMN_W'(column);
      r.int_digits  = COUNT_W'(int_digits);
      r.frac_digits = COUNT_W'(frac_digits);
      return r;
   endfunction

   // Shaped random request: mostly printable counts, some overflow
   function automatic req_type random_req();
      req_type            r;
      logic [VALUE_W-1:0] p;
      int                 kind;
      int                 total;
      int                 nint;

      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: r.value = {$urandom, $urandom};
         4, 5, 6:    r.value = VALUE_W'($urandom_range(0, 99999));
         7:          r.value = '0;
         8: begin
            p = VALUE_W'(1);
            repeat ($urandom_range(0, 19)) p = p * VALUE_W'(10);
            r.value = p * VALUE_W'($urandom_range(1, 9));
         end
         default:    r.value = '1 - VALUE_W'($urandom_range(0, 3));
      endcase

      r.row    = ROW_W'($urandom_range(0, 3));
      r.column = ($urandom_range(0, 4) == 0) ? COLUMN_W'($urandom_range(20, 31))
                                             : COLUMN_W'($urandom_range(0, 19));

      if ($urandom_range(0, 9) == 0) begin
         nint          = $urandom_range(0, 31);
         r.int_digits  = COUNT_W'(nint);
         r.frac_digits = COUNT_W'($urandom_range((nint > 20) ? 0 : 21 - nint, 31));
      end else begin
         total         = $urandom_range(0, MAX_DIGITS_DEF);
         nint          = $urandom_range(0, total);
         r.int_digits  = COUNT_W'(nint);
         r.frac_digits = COUNT_W'(total - nint);
      end
      return r;
   endfunction

   // Mostly back to back or short gaps, now and then a long one
   function automatic int pick_gap();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 55) return 0;
      if (kind < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   // Offer one request after a random gap and hold it until taken
   task automatic send_request(input req_type r);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      if (int'(r.int_digits) + int'(r.frac_digits) > MAX_DIGITS_DEF) dash_requests++;
      if (r.int_digits == '0) pointless_requests++;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      req_type directed[$];
      int      i;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed edge cases
      directed.push_back(make_req(64'd0, 0, 0, 0, 0));
      directed.push_back(make_req(64'd0, 1, 3, 1, 0));
      directed.push_back(make_req(64'd0, 2, 7, 5, 0));
      directed.push_back(make_req(64'd0, 0, 1, 3, 2));
      directed.push_back(make_req('1, 0, 0, 20, 0));
      directed.push_back(make_req('1, 1, 0, 0, 20));
      directed.push_back(make_req(64'd12345, 2, 4, 0, 3));
      directed.push_back(make_req(64'd987, 0, 0, 21, 0));
      directed.push_back(make_req(64'd987, 3, 31, 31, 31));
      directed.push_back(make_req(64'd987, 1, 2, 0, 21));
      directed.push_back(make_req(64'd987, 2, 5, 10, 11));
      directed.push_back(make_req(64'd42, 3, 31, 4, 0));
      directed.push_back(make_req(64'd42, 3, 19, 2, 1));
      directed.push_back(make_req(64'd1000, 0, 10, 8, 0));
      directed.push_back(make_req(64'd100, 1, 12, 2, 1));
      directed.push_back(make_req(64'd5, 2, 0, 4, 2));
      directed.push_back(make_req(64'd10000000000000000000, 0, 0, 20, 0));
      directed.push_back(make_req(64'h5555_5555_5555_5555, 1, 21, 10, 10));
      directed.push_back(make_req(64'hAAAA_AAAA_AAAA_AAAA, 2, 10, 31, 0));
      directed.push_back(make_req(64'd7, 0, 0, 1, 0));
      for (i = 0; i < directed.size(); i++) send_request(directed[i]);

      for (i = 0; i < RANDOM_REQUESTS; i++) send_request(random_req());

      @(negedge clock);
      req_valid = 1'b0;

      // wait for every owed byte, then let stray output show itself
      while (pending_bytes != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d response bytes", requests_taken, bytes_taken);
      $display("%0d requests overflowed to dashes, %0d had no integer digits",
               dash_requests, pointless_requests);
      if (fail_count == 0) begin
         $display("decimal_number_formatter test passed");
      end else begin
         $display("decimal_number_formatter test failed");
      end
      $finish;
   end

endmodule
